[hdl/alpha_over_compositor_assert.svh]
// assertion macros for the alpha over compositor
`ifndef ALPHA_OVER_COMPOSITOR_ASSERT_SVH
`define ALPHA_OVER_COMPOSITOR_ASSERT_SVH

// condition in this cycle implies a check in the same cycle
`define AOC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("alpha over compositor check failed");

// condition in this cycle implies a check in the next cycle
`define AOC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("alpha over compositor check failed");

`endif

[hdl/aoc_pkg.sv]
// types and constants of the alpha over compositor
package aoc_pkg;

   // field and datapath widths
   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;
   localparam int WGT_W  = 16;
   localparam int NUM_W  = 24;
   localparam int QUO_W  = 8;

   // fully opaque alpha
   localparam logic [CH_W-1:0] FULL_ALPHA = 8'd255;

   // cycles from accepted request to result strobe
   localparam int LATENCY = QUO_W + 4;

   // colour triple, index 0 red, 1 green, 2 blue
   typedef logic [NUM_CH-1:0][CH_W-1:0] colour_type;

   // payload of one divider stage
   typedef struct packed {
      logic                            transparent;
      logic [WGT_W-1:0]                den;
      logic [NUM_CH-1:0][NUM_W-1:0]    rem;
      logic [NUM_CH-1:0][QUO_W-1:0]    quo;
   } div_data_type;

endpackage

[hdl/alpha_over_compositor.sv]
// alpha over compositor: rgba8 foreground over rgba8 background, pipelined
//
// One pixel pair may be started in every clock cycle; busy is always low and
// the result strobe rsp_valid follows the accepted start through the stages
// named next. Three stages form the alpha weights, the weighted products and
// the numerator sums, eight stages of a restoring divider give one quotient
// bit each, and a last register drives the result ports. The receiver cannot
// hold results off, so nothing in the pipeline ever stalls. When both alphas
// are zero the colours come out as zero and rsp_fully_transparent is set.
`include "alpha_over_compositor_assert.svh"

module alpha_over_compositor
   import aoc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [CH_W-1:0] req_fg_red,
   input  logic [CH_W-1:0] req_fg_green,
   input  logic [CH_W-1:0] req_fg_blue,
   input  logic [CH_W-1:0] req_fg_alpha,
   input  logic [CH_W-1:0] req_bg_red,
   input  logic [CH_W-1:0] req_bg_green,
   input  logic [CH_W-1:0] req_bg_blue,
   input  logic [CH_W-1:0] req_bg_alpha,
   output logic            rsp_valid,
   output logic [CH_W-1:0] rsp_out_red,
   output logic [CH_W-1:0] rsp_out_green,
   output logic [CH_W-1:0] rsp_out_blue,
   output logic            rsp_fully_transparent
);

   logic req_xfer;

   // stage 1: alpha weights
   logic             s1_vld_ff, s1_vld_in;
   colour_type       s1_cf_ff, s1_cf_in;
   colour_type       s1_cb_ff, s1_cb_in;
   logic [WGT_W-1:0] s1_wf_ff, s1_wf_in;
   logic [WGT_W-1:0] s1_wb_ff, s1_wb_in;
   logic             s1_tr_ff, s1_tr_in;

   // stage 2: weighted products and divisor
   logic                         s2_vld_ff, s2_vld_in;
   logic [NUM_CH-1:0][NUM_W-1:0] s2_pf_ff, s2_pf_in;
   logic [NUM_CH-1:0][NUM_W-1:0] s2_pb_ff, s2_pb_in;
   logic [WGT_W-1:0]             s2_den_ff, s2_den_in;
   logic                         s2_tr_ff, s2_tr_in;

   // divider pipeline, entry 0 holds the numerator sums
   logic [QUO_W:0] div_vld_ff, div_vld_in;
   div_data_type   div_ff [0:QUO_W];
   div_data_type   div_in [0:QUO_W];

   // result register
   logic       out_vld_ff, out_vld_in;
   colour_type out_col_ff, out_col_in;
   logic       out_tr_ff, out_tr_in;

   // no back-pressure anywhere, a start is always taken
   assign busy     = 1'b0;
   assign req_xfer = start & ~busy;

   // weights: af*255 and ab*(255-af)
   always_comb begin
      s1_vld_in = req_xfer;
      s1_cf_in  = {req_fg_blue, req_fg_green, req_fg_red};
      s1_cb_in  = {req_bg_blue, req_bg_green, req_bg_red};
      s1_wf_in  = {req_fg_alpha, {CH_W{1'b0}}} - WGT_W'(req_fg_alpha);
      s1_wb_in  = WGT_W'(req_bg_alpha) * WGT_W'(FULL_ALPHA - req_fg_alpha);
      s1_tr_in  = (req_fg_alpha == '0) && (req_bg_alpha == '0);
   end

   // products of colour and weight, divisor sum
   always_comb begin
      s2_vld_in = s1_vld_ff;
      s2_den_in = s1_wf_ff + s1_wb_ff;
      s2_tr_in  = s1_tr_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         s2_pf_in[c] = NUM_W'(s1_cf_ff[c]) * NUM_W'(s1_wf_ff);
         s2_pb_in[c] = NUM_W'(s1_cb_ff[c]) * NUM_W'(s1_wb_ff);
      end
   end

   // numerator sums feed the divider
   always_comb begin
      div_in[0].transparent = s2_tr_ff;
      div_in[0].den         = s2_den_ff;
      div_in[0].quo         = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         div_in[0].rem[c] = s2_pf_ff[c] + s2_pb_ff[c];
      end
   end

   assign div_vld_in = {div_vld_ff[QUO_W-1:0], s2_vld_ff};

   // restoring divider, one quotient bit per stage, msb first
   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      localparam int SH = QUO_W - 1 - i;
      logic [NUM_W-1:0] den_sh;

      assign den_sh = NUM_W'(div_ff[i].den) << SH;

      always_comb begin
         div_in[i+1] = div_ff[i];
         for (int c = 0; c < NUM_CH; c++) begin
            if (div_ff[i].rem[c] >= den_sh) begin
               div_in[i+1].rem[c]     = div_ff[i].rem[c] - den_sh;
               div_in[i+1].quo[c][SH] = 1'b1;
            end
         end
      end
   end

   // result: zero colours when both alphas are zero
   always_comb begin
      out_vld_in = div_vld_ff[QUO_W];
      out_tr_in  = div_ff[QUO_W].transparent;
      for (int c = 0; c < NUM_CH; c++) begin
         out_col_in[c] = div_ff[QUO_W].transparent ? '0 : div_ff[QUO_W].quo[c];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         div_vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         div_vld_ff <= div_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_cf_ff   <= s1_cf_in;
      s1_cb_ff   <= s1_cb_in;
      s1_wf_ff   <= s1_wf_in;
      s1_wb_ff   <= s1_wb_in;
      s1_tr_ff   <= s1_tr_in;
      s2_pf_ff   <= s2_pf_in;
      s2_pb_ff   <= s2_pb_in;
      s2_den_ff  <= s2_den_in;
      s2_tr_ff   <= s2_tr_in;
      div_ff     <= div_in;
      out_col_ff <= out_col_in;
      out_tr_ff  <= out_tr_in;
   end

   // result ports
   assign rsp_valid             = out_vld_ff;
   assign rsp_out_red           = out_col_ff[0];
   assign rsp_out_green         = out_col_ff[1];
   assign rsp_out_blue          = out_col_ff[2];
   assign rsp_fully_transparent = out_tr_ff;

   // checks
   `AOC_ASSERT_IMPLY(a_rsp_from_start, clock, reset, rsp_valid, $past(start, LATENCY))
   `AOC_ASSERT_IMPLY(a_transparent_flag, clock, reset, rsp_valid, rsp_fully_transparent == $past((req_fg_alpha == '0) && (req_bg_alpha == '0), LATENCY))
   `AOC_ASSERT_IMPLY(a_transparent_zero, clock, reset, rsp_valid && rsp_fully_transparent, (rsp_out_red == '0) && (rsp_out_green == '0) && (rsp_out_blue == '0))
   `AOC_ASSERT_IMPLY(a_div_remainder, clock, reset, div_vld_ff[QUO_W] && !div_ff[QUO_W].transparent, (div_ff[QUO_W].rem[0] < NUM_W'(div_ff[QUO_W].den)) && (div_ff[QUO_W].rem[1] < NUM_W'(div_ff[QUO_W].den)) && (div_ff[QUO_W].rem[2] < NUM_W'(div_ff[QUO_W].den)))

endmodule
